FILE: hdl/line_segment_orientation_unit_defines.svh
// Assertion macros for the line segment orientation unit.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef LINE_SEGMENT_ORIENTATION_UNIT_DEFINES_SVH
`define LINE_SEGMENT_ORIENTATION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LSO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LSO_ASSERT(lbl, clk, rstn, prop, msg)
`define LSO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hdl/lso_pkg.sv
// Shared constants, types and the arctangent table of the orientation unit.
// No dependencies.
`default_nettype none
package lso_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 16;
  localparam int unsigned ANGLE_WIDTH_DEF   = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // datapath widths: x/y carry the prescaled differences, z is in units pi = 2^31
  localparam int unsigned CORDIC_W = 64;
  localparam int unsigned ZW       = 34;
  localparam int unsigned ATAN_N   = 32;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'd1 << 31);

  // atan(2^-i), pi = 2^31
  localparam logic [31:0] ATAN_LUT [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic                       vert;
    logic                       horiz;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ZW-1:0]       z;
  } lso_stage_t;

endpackage
`default_nettype wire

FILE: hdl/lso_seg_if.sv
// Segment input channel: valid/ready plus the two end points.
// No dependencies.
`default_nettype none
interface lso_seg_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_column;
  logic signed [COORD_WIDTH-1:0] start_row;
  logic signed [COORD_WIDTH-1:0] end_column;
  logic signed [COORD_WIDTH-1:0] end_row;

  modport source (output valid, start_column, start_row, end_column, end_row, input ready);
  modport sink   (input valid, start_column, start_row, end_column, end_row, output ready);
endinterface
`default_nettype wire

FILE: hdl/lso_ori_if.sv
// Orientation output channel: valid/ready plus the binary angle.
// No dependencies.
`default_nettype none
interface lso_ori_if #(
  parameter int unsigned ANGLE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [ANGLE_WIDTH-1:0] orientation;

  modport source (output valid, orientation, input ready);
  modport sink   (input valid, orientation, output ready);
endinterface
`default_nettype wire

FILE: hdl/lso_prep.sv
// Entry stage: end point differences, flip to the right half plane, prescale.
// Uses lso_pkg.
`default_nettype none
module lso_prep #(
  parameter int unsigned COORD_WIDTH = lso_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_column_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_row_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_column_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_row_i,
  output logic                               vld_o,
  output lso_pkg::lso_stage_t                stage_o
);
  localparam int unsigned CW       = lso_pkg::CORDIC_W;
  localparam int unsigned DW       = COORD_WIDTH + 1;
  localparam int unsigned PRESCALE = 58 - COORD_WIDTH;

  logic signed [DW-1:0] dx, dy, dx_abs, dy_adj;
  logic                 vld_q;
  lso_pkg::lso_stage_t  stage_d, stage_q;

  assign dx = DW'(end_column_i) - DW'(start_column_i);
  assign dy = DW'(end_row_i) - DW'(start_row_i);

  // leftward segments: negate both, angle mod pi unchanged
  always_comb begin
    if (dx[DW-1]) begin
      dx_abs = -dx;
      dy_adj = -dy;
    end else begin
      dx_abs = dx;
      dy_adj = dy;
    end
  end

  always_comb begin
    stage_d.vert  = (dx == '0);
    stage_d.horiz = (dy == '0);
    stage_d.x     = CW'(dx_abs) <<< PRESCALE;
    stage_d.y     = CW'(dy_adj) <<< PRESCALE;
    stage_d.z     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign vld_o   = vld_q;
  assign stage_o = stage_q;
endmodule
`default_nettype wire

FILE: hdl/lso_cell.sv
// One CORDIC vectoring micro-rotation with its output register.
// Uses lso_pkg (stage type, arctangent table).
`default_nettype none
module lso_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 vld_i,
  input  wire lso_pkg::lso_stage_t  stage_i,
  output logic                      vld_o,
  output lso_pkg::lso_stage_t       stage_o
);
  localparam int unsigned CW = lso_pkg::CORDIC_W;
  localparam int unsigned ZW = lso_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN = ZW'(lso_pkg::ATAN_LUT[STAGE]);

  logic signed [CW-1:0] x_sh, y_sh;
  logic                 y_pos;
  logic                 vld_q;
  lso_pkg::lso_stage_t  stage_d, stage_q;

  // arithmetic shifts are floor divisions
  assign x_sh  = $signed(stage_i.x) >>> STAGE;
  assign y_sh  = $signed(stage_i.y) >>> STAGE;
  assign y_pos = !stage_i.y[CW-1] && (stage_i.y != '0);

  always_comb begin
    stage_d.vert  = stage_i.vert;
    stage_d.horiz = stage_i.horiz;
    if (y_pos) begin
      stage_d.x = stage_i.x + y_sh;
      stage_d.y = stage_i.y - x_sh;
      stage_d.z = stage_i.z + ATAN;
    end else begin
      stage_d.x = stage_i.x - y_sh;
      stage_d.y = stage_i.y + x_sh;
      stage_d.z = stage_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign vld_o   = vld_q;
  assign stage_o = stage_q;
endmodule
`default_nettype wire

FILE: hdl/lso_post.sv
// Exit stage: special cases, fold into [0, pi), round (or widen) to the output width.
// Uses lso_pkg.
`default_nettype none
module lso_post #(
  parameter int unsigned ANGLE_WIDTH = lso_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    vld_i,
  input  wire lso_pkg::lso_stage_t     stage_i,
  output logic                         vld_o,
  output logic [ANGLE_WIDTH-1:0]       orientation_o
);
  localparam int unsigned ZW = lso_pkg::ZW;
  localparam logic [ANGLE_WIDTH-1:0] VERT_ANGLE = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

  logic signed [ZW-1:0]   z_wrap, z_fold;
  logic [ANGLE_WIDTH-1:0] angle_rnd, orientation_d, orientation_q;
  logic                   vld_q;

  assign z_wrap = stage_i.z + lso_pkg::HALF_TURN;

  always_comb begin
    if (!stage_i.z[ZW-1]) begin
      z_fold = stage_i.z;
    end else if (!z_wrap[ZW-1]) begin
      z_fold = z_wrap;
    end else begin
      z_fold = '0;
    end
  end

  if (ANGLE_WIDTH < 31) begin : g_round
    localparam int unsigned     SH   = 31 - ANGLE_WIDTH;
    localparam logic [ZW:0]     BIAS = (ZW + 1)'(1) << (SH - 1);
    logic [ZW:0] z_sum, z_shr;
    assign z_sum     = {1'b0, z_fold} + BIAS;
    assign z_shr     = z_sum >> SH;
    // a result rounded up to pi drops out of the mask and wraps to zero
    assign angle_rnd = z_shr[ANGLE_WIDTH-1:0];
  end else begin : g_widen
    logic [ZW:0] z_shl;
    assign z_shl     = {1'b0, z_fold} << (ANGLE_WIDTH - 31);
    assign angle_rnd = z_shl[ANGLE_WIDTH-1:0];
  end

  always_comb begin
    priority if (stage_i.vert) begin
      orientation_d = VERT_ANGLE;
    end else if (stage_i.horiz) begin
      orientation_d = '0;
    end else begin
      orientation_d = angle_rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      orientation_q <= orientation_d;
    end
  end

  assign vld_o         = vld_q;
  assign orientation_o = orientation_q;
endmodule
`default_nettype wire

FILE: hdl/line_segment_orientation_unit.sv
// Line segment orientation unit: top level, CORDIC chain and its flow control.
// Uses lso_pkg, lso_seg_if, lso_ori_if, lso_prep, lso_cell, lso_post and the defines header.
//
// Takes one segment word per cycle and returns its undirected orientation in
// units of pi/2^ANGLE_WIDTH, 0 horizontal and 2^(ANGLE_WIDTH-1) vertical. Each
// word passes an entry stage, CORDIC_STAGES rotation cells and an exit stage,
// each with its own output register. The chain advances as one: while the
// output word is held and not taken, every stage holds and seg_i.ready is
// low; otherwise a new segment is taken each cycle.
`default_nettype none
`include "line_segment_orientation_unit_defines.svh"
module line_segment_orientation_unit #(
  parameter int unsigned COORD_WIDTH   = lso_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH   = lso_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned CORDIC_STAGES = lso_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lso_seg_if.sink    seg_i,
  lso_ori_if.source  ori_o
);
  localparam logic [ANGLE_WIDTH-1:0] VERT_ANGLE = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

  logic                  en;
  logic [CORDIC_STAGES:0] vld_w;
  lso_pkg::lso_stage_t   stage_w [CORDIC_STAGES+1];

  assign en          = !ori_o.valid || ori_o.ready;
  assign seg_i.ready = en;

  lso_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .vld_i         (seg_i.valid),
    .start_column_i(seg_i.start_column),
    .start_row_i   (seg_i.start_row),
    .end_column_i  (seg_i.end_column),
    .end_row_i     (seg_i.end_row),
    .vld_o         (vld_w[0]),
    .stage_o       (stage_w[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    lso_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (en),
      .vld_i  (vld_w[g]),
      .stage_i(stage_w[g]),
      .vld_o  (vld_w[g+1]),
      .stage_o(stage_w[g+1])
    );
  end

  lso_post #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_post (
    .clk_i,
    .rst_ni,
    .en_i         (en),
    .vld_i        (vld_w[CORDIC_STAGES]),
    .stage_i      (stage_w[CORDIC_STAGES]),
    .vld_o        (ori_o.valid),
    .orientation_o(ori_o.orientation)
  );

  // a taken segment occupies the entry stage next cycle
  `LSO_ASSERT_NEXT(a_take_fills_entry, clk_i, rst_ni, seg_i.valid && seg_i.ready, vld_w[0], "taken segment lost at entry stage")
  // a stalled chain keeps its occupancy
  `LSO_ASSERT_NEXT(a_stall_holds_chain, clk_i, rst_ni, !en, $stable(vld_w) && ori_o.valid, "chain moved while stalled")
  // vertical segments leave as exactly half scale
  `LSO_ASSERT_NEXT(a_vertical_word, clk_i, rst_ni, en && vld_w[CORDIC_STAGES] && stage_w[CORDIC_STAGES].vert, ori_o.valid && (ori_o.orientation == VERT_ANGLE), "vertical segment gave wrong angle")
endmodule
`default_nettype wire
